// ===== design/dir_pkg.sv =====
// Package for the DFT impedance ratio core: widths, register indexes and the divider step.
package dir_pkg;

  // Configuration register indexes.
  localparam logic REG_ZTIA_REAL = 1'b0;
  localparam logic REG_ZTIA_IMAG = 1'b1;

  // Reset value of the real part of the TIA impedance (1000 ohms in Q20.12).
  localparam logic [31:0] ZTIA_REAL_RESET = 32'd4096000;
  localparam int ZTIA_FRAC_BITS = 12;
  localparam int DEF_OUT_FRAC_BITS = 16;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DIV = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  // Output part width, divisor width, quotient bits and product width.
  localparam int OW = 48;
  localparam int DW = 48;
  localparam int QB = 49;
  localparam int PW = 72;

  // One lane of the divider: partial remainder, dividend bits still to come
  // shifted against quotient bits already found, sign and overflow marks.
  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QB-1:0] mq;
    logic          neg;
    logic          ovf;
  } div_lane_t;

  // One restoring division step: bring down one dividend bit, produce one quotient bit.
  function automatic div_lane_t div_step(div_lane_t x, logic [DW-1:0] den);
    logic [DW:0] r2;
    logic [DW:0] diff;
    logic        qbit;
    div_lane_t   y;
    r2   = {x.rem, x.mq[QB-1]};
    diff = r2 - {1'b0, den};
    qbit = (r2 >= {1'b0, den});
    y     = x;
    y.rem = qbit ? diff[DW-1:0] : r2[DW-1:0];
    y.mq  = {x.mq[QB-2:0], qbit};
    return y;
  endfunction

endpackage

// ===== design/dft_impedance_ratio_core.sv =====
// Top level: complex ratio Zdut = Vdut * Ztia / Vtia as a fully pipelined datapath.
// Input accept to output valid: stages 1 to 5, 49 divider stages, output register.
// One item per cycle unless stalled; the 49-stage bit-per-stage divider sets the depth.
// A stall on the output holds the whole pipeline; nothing is dropped or repeated.
// Reset (synchronous, rst high) clears all valid bits and loads Ztia = 1000 + 0j ohms.
module dft_impedance_ratio_core #(
  parameter int OUT_FRAC_BITS = dir_pkg::DEF_OUT_FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // dut_real_word, dut_imag_word, tia_real_word, tia_imag_word (from bit 0 up)
  input  logic [127:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // z_real[47:0], z_imag[95:48], status[97:96], zero padding
  output logic [103:0] m_tdata,
  input  logic         cfg_wen,
  input  logic         cfg_addr,
  input  logic [31:0]  cfg_wdata
);
  import dir_pkg::*;

  localparam int MW = PW + OUT_FRAC_BITS + DW;
  localparam int HW = MW - QB;

  logic en;
  logic signed [31:0] zr, zi;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      zr <= ZTIA_REAL_RESET;
      zi <= '0;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_ZTIA_REAL: zr <= cfg_wdata;
        REG_ZTIA_IMAG: zi <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  // Input decode: payload sign extension and negation of imaginary parts.
  logic signed [18:0] a0, b0, c0, d0;
  assign a0 = 19'(signed'(s_tdata[17:0]));
  assign b0 = -19'(signed'(s_tdata[49:32]));
  assign c0 = 19'(signed'(s_tdata[81:64]));
  assign d0 = -19'(signed'(s_tdata[113:96]));

  // Stage 1: Vdut * Ztia partial products, squared TIA parts.
  logic v1, z1;
  logic signed [50:0] p_azr, p_bzi, p_azi, p_bzr;
  logic signed [18:0] c1, d1;
  logic signed [37:0] cc1, dd1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= s_tvalid;
    if (en) begin
      p_azr <= a0 * zr;
      p_bzi <= b0 * zi;
      p_azi <= a0 * zi;
      p_bzr <= b0 * zr;
      c1    <= c0;
      d1    <= d0;
      cc1   <= c0 * c0;
      dd1   <= d0 * d0;
      z1    <= ((c0 == '0) && (d0 == '0)) || ((zr == '0) && (zi == '0));
    end
  end

  // Stage 2: numerator N = Vdut * Ztia, and divisor scaled to Q12.
  logic v2, z2;
  logic signed [51:0] nr2, ni2;
  logic signed [18:0] c2, d2;
  logic [DW-1:0] den2;
  logic [35:0] mag2;
  assign mag2 = cc1[35:0] + dd1[35:0];
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      nr2  <= 52'(p_azr) - 52'(p_bzi);
      ni2  <= 52'(p_azi) + 52'(p_bzr);
      c2   <= c1;
      d2   <= d1;
      den2 <= {mag2, {ZTIA_FRAC_BITS{1'b0}}};
      z2   <= z1;
    end
  end

  // Stage 3: N * conj(Vtia) partial products.
  logic v3, z3;
  logic signed [70:0] p_nrc, p_nid, p_nic, p_nrd;
  logic [DW-1:0] den3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      p_nrc <= nr2 * c2;
      p_nid <= ni2 * d2;
      p_nic <= ni2 * c2;
      p_nrd <= nr2 * d2;
      den3  <= den2;
      z3    <= z2;
    end
  end

  // Stage 4: real and imaginary dividends.
  logic v4, z4;
  logic signed [PW-1:0] pr4, pi4;
  logic [DW-1:0] den4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      pr4  <= PW'(p_nrc) + PW'(p_nid);
      pi4  <= PW'(p_nic) - PW'(p_nrd);
      den4 <= den3;
      z4   <= z3;
    end
  end

  // Stage 5: magnitudes, output scaling, overflow check and divider load.
  logic [PW-1:0] mr, mi;
  logic [MW-1:0] wr, wi;
  div_lane_t ldr, ldi;
  assign mr = pr4[PW-1] ? PW'(-pr4) : PW'(pr4);
  assign mi = pi4[PW-1] ? PW'(-pi4) : PW'(pi4);
  assign wr = {{DW{1'b0}}, mr, {OUT_FRAC_BITS{1'b0}}};
  assign wi = {{DW{1'b0}}, mi, {OUT_FRAC_BITS{1'b0}}};
  always_comb begin
    ldr.rem = wr[QB+DW-1:QB];
    ldr.mq  = wr[QB-1:0];
    ldr.neg = pr4[PW-1];
    ldr.ovf = (wr[MW-1:QB] >= HW'(den4));
    ldi.rem = wi[QB+DW-1:QB];
    ldi.mq  = wi[QB-1:0];
    ldi.neg = pi4[PW-1];
    ldi.ovf = (wi[MW-1:QB] >= HW'(den4));
  end

  // Divider pipeline: one quotient bit per stage for each lane.
  logic          dv [0:QB];
  logic          dz [0:QB];
  logic [DW-1:0] dd [0:QB];
  div_lane_t     lr [0:QB];
  div_lane_t     li [0:QB];

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (en) dv[0] <= v4;
    if (en) begin
      dz[0] <= z4;
      dd[0] <= den4;
      lr[0] <= ldr;
      li[0] <= ldi;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) dv[k+1] <= 1'b0;
      else if (en) dv[k+1] <= dv[k];
      if (en) begin
        dz[k+1] <= dz[k];
        dd[k+1] <= dd[k];
        lr[k+1] <= div_step(lr[k], dd[k]);
        li[k+1] <= div_step(li[k], dd[k]);
      end
    end
  end

  // Final stage: round half away from zero, saturate, apply sign, zero on zero divide, set status.
  logic [QB:0] qr, qi, lim_r, lim_i;
  logic sat_r, sat_i;
  logic [OW-1:0] or_r, or_i;
  logic [1:0] st;
  always_comb begin
    qr = {1'b0, lr[QB].mq} + (QB+1)'({lr[QB].rem, 1'b0} >= {1'b0, dd[QB]});
    qi = {1'b0, li[QB].mq} + (QB+1)'({li[QB].rem, 1'b0} >= {1'b0, dd[QB]});
    lim_r = lr[QB].neg ? (QB+1)'(1) << (OW-1) : ((QB+1)'(1) << (OW-1)) - 1'b1;
    lim_i = li[QB].neg ? (QB+1)'(1) << (OW-1) : ((QB+1)'(1) << (OW-1)) - 1'b1;
    sat_r = lr[QB].ovf || (qr > lim_r);
    sat_i = li[QB].ovf || (qi > lim_i);
    or_r  = sat_r ? lim_r[OW-1:0] : qr[OW-1:0];
    or_i  = sat_i ? lim_i[OW-1:0] : qi[OW-1:0];
    if (lr[QB].neg) or_r = -or_r;
    if (li[QB].neg) or_i = -or_i;
    if (dz[QB]) begin
      or_r = '0;
      or_i = '0;
      st   = ST_ZERO_DIV;
    end else if (sat_r || sat_i) begin
      st = ST_SAT;
    end else begin
      st = ST_OK;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= dv[QB];
    if (en) m_tdata <= {6'b0, st, or_i, or_r};
  end

endmodule
